/* sv/assert_macros.svh */
// assertion macros shared by the rtl files
// no dependencies

`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    `ASSERT_CLK(label, clk, rst_n, !(cond), msg)

`endif

/* sv/bdhs_pkg.sv */
// shared types and constants of the directional hit scan block
// no dependencies

package bdhs_pkg;

    localparam int unsigned TILE_SIZE_DEF = 64;
    localparam int unsigned CRD_W         = 6;
    localparam int unsigned SIZE_W        = 7;
    localparam int unsigned ROW_W         = 64;
    localparam int unsigned OFS_W         = 32;
    localparam int unsigned MODE_W        = 2;
    localparam int unsigned Q_DEPTH       = 2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef enum logic [1:0] {
        DIR_LEFT   = 2'd0,
        DIR_RIGHT  = 2'd1,
        DIR_TOP    = 2'd2,
        DIR_BOTTOM = 2'd3
    } t_dir;

    localparam logic [MODE_W-1:0] MODE_NONE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SOLID = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MASK  = 2'd2;

    typedef struct packed {
        logic              kind;
        logic [CRD_W-1:0]  row_idx;
        logic [ROW_W-1:0]  row_bits;
        t_dir              dir;
        logic [CRD_W-1:0]  x0;
        logic [CRD_W-1:0]  y0;
        logic [CRD_W-1:0]  x1;
        logic [CRD_W-1:0]  y1;
        logic              empty;
        logic [OFS_W-1:0]  ox;
        logic [OFS_W-1:0]  oy;
    } t_cmd;

    typedef struct packed {
        logic              hit;
        logic [OFS_W-1:0]  hit_x;
        logic [OFS_W-1:0]  hit_y;
    } t_res;

endpackage

/* sv/bitmask_directional_hit_scan.sv */
// top level of the directional hit scan over a tile obstacle bitmask
// uses bdhs_pkg, bdhs_front, bdhs_fifo and bdhs_back

// A row write is done by the back end straight from S_IDLE. A query in bitmask
// mode reads the clipped rectangle's rows one per cycle from the mask ram, bottom
// row first, through its single read port, then passes S_FIN and S_OUT.
// Queries in the other tile modes, or with an empty rectangle, need no scan.
// Two-entry queues sit between the front and back ends and on the result side,
// so items are accepted while a query scans. The mask reads as all zero after
// reset. The user writes tile_mode only while the block is idle; nothing checks.

module bitmask_directional_hit_scan
    import bdhs_pkg::*;
#(
    parameter int unsigned TILE_SIZE = TILE_SIZE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [MODE_W-1:0] i_cfg_data,
    input  logic              push,
    output logic              full,
    input  logic              i_kind,
    input  logic [CRD_W-1:0]  i_row_index,
    input  logic [ROW_W-1:0]  i_row_bits,
    input  logic [1:0]        i_direction,
    input  logic [CRD_W-1:0]  i_rect_x,
    input  logic [CRD_W-1:0]  i_rect_y,
    input  logic [SIZE_W-1:0] i_rect_w,
    input  logic [SIZE_W-1:0] i_rect_h,
    input  logic [OFS_W-1:0]  i_offset_x,
    input  logic [OFS_W-1:0]  i_offset_y,
    output logic              empty,
    input  logic              pop,
    output logic              o_hit,
    output logic [OFS_W-1:0]  o_hit_x,
    output logic [OFS_W-1:0]  o_hit_y
);

    logic [MODE_W-1:0] r_tile_mode;
    t_cmd              front_cmd, q_cmd;
    t_res              back_res, q_res;
    logic              cmd_empty, cmd_pop, res_full, res_push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_mode <= MODE_NONE;
        end else if (i_cfg_we) begin
            r_tile_mode <= i_cfg_data;
        end
    end

    bdhs_front #(
        .TILE_SIZE (TILE_SIZE)
    ) u_front (
        .i_kind      (i_kind),
        .i_row_index (i_row_index),
        .i_row_bits  (i_row_bits),
        .i_direction (i_direction),
        .i_rect_x    (i_rect_x),
        .i_rect_y    (i_rect_y),
        .i_rect_w    (i_rect_w),
        .i_rect_h    (i_rect_h),
        .i_offset_x  (i_offset_x),
        .i_offset_y  (i_offset_y),
        .o_cmd       (front_cmd)
    );

    bdhs_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (Q_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_cmd),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (q_cmd),
        .o_empty (cmd_empty)
    );

    bdhs_back #(
        .TILE_SIZE (TILE_SIZE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mode      (r_tile_mode),
        .i_cmd       (q_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (back_res)
    );

    bdhs_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (q_res),
        .o_empty (empty)
    );

    assign o_hit   = q_res.hit;
    assign o_hit_x = q_res.hit_x;
    assign o_hit_y = q_res.hit_y;

endmodule

/* sv/bdhs_ram.sv */
// generic single write port ram with registered read
// no dependencies

module bdhs_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/bdhs_fifo.sv */
// small register queue used between front and back and on the result side
// uses assert_macros.svh

`include "assert_macros.svh"

module bdhs_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, n_wp, r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (do_pop) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    `ASSERT_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt > CW'(DEPTH), "fifo count beyond depth")

endmodule

/* sv/bdhs_front.sv */
// front end: classifies an incoming item and clips the query rectangle
// uses bdhs_pkg

module bdhs_front
    import bdhs_pkg::*;
#(
    parameter int unsigned TILE_SIZE = TILE_SIZE_DEF
) (
    input  logic              i_kind,
    input  logic [CRD_W-1:0]  i_row_index,
    input  logic [ROW_W-1:0]  i_row_bits,
    input  logic [1:0]        i_direction,
    input  logic [CRD_W-1:0]  i_rect_x,
    input  logic [CRD_W-1:0]  i_rect_y,
    input  logic [SIZE_W-1:0] i_rect_w,
    input  logic [SIZE_W-1:0] i_rect_h,
    input  logic [OFS_W-1:0]  i_offset_x,
    input  logic [OFS_W-1:0]  i_offset_y,
    output t_cmd              o_cmd
);

    localparam logic [SIZE_W:0] LAST = (SIZE_W + 1)'(TILE_SIZE - 1);

    logic [SIZE_W:0] x_end, y_end;

    assign x_end = (SIZE_W + 1)'(i_rect_x) + (SIZE_W + 1)'(i_rect_w) - 1'b1;
    assign y_end = (SIZE_W + 1)'(i_rect_y) + (SIZE_W + 1)'(i_rect_h) - 1'b1;

    always_comb begin
        o_cmd          = '0;
        o_cmd.kind     = i_kind;
        o_cmd.row_idx  = i_row_index;
        o_cmd.row_bits = i_row_bits;
        o_cmd.dir      = t_dir'(i_direction);
        o_cmd.x0       = i_rect_x;
        o_cmd.y0       = i_rect_y;
        o_cmd.x1       = (x_end > LAST) ? CRD_W'(TILE_SIZE - 1) : x_end[CRD_W-1:0];
        o_cmd.y1       = (y_end > LAST) ? CRD_W'(TILE_SIZE - 1) : y_end[CRD_W-1:0];
        // corner outside the tile or zero size means nothing to hit
        o_cmd.empty    = (i_rect_w == '0) || (i_rect_h == '0)
                      || ((SIZE_W + 1)'(i_rect_x) > LAST)
                      || ((SIZE_W + 1)'(i_rect_y) > LAST);
        o_cmd.ox       = i_offset_x;
        o_cmd.oy       = i_offset_y;
    end

endmodule

/* sv/bdhs_back.sv */
// back end: row writes into the mask ram and the row-by-row query scan
// uses bdhs_pkg, bdhs_ram and assert_macros.svh

`include "assert_macros.svh"

module bdhs_back
    import bdhs_pkg::*;
#(
    parameter int unsigned TILE_SIZE = TILE_SIZE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [MODE_W-1:0] i_mode,
    input  t_cmd              i_cmd,
    input  logic              i_cmd_empty,
    output logic              o_cmd_pop,
    input  logic              i_res_full,
    output logic              o_res_push,
    output t_res              o_res
);

    localparam int unsigned AW = $clog2(TILE_SIZE);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FIN  = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    t_dir                 r_dir;
    logic [CRD_W-1:0]     r_y0, r_addr, r_rd_row, r_hx, r_hy;
    logic [TILE_SIZE-1:0] r_cm, n_cm, r_row_vld;
    logic [OFS_W-1:0]     r_ox, r_oy;
    logic                 r_found, r_rd_pend, r_rd_vld;

    logic                 is_write, is_query, row_ok, start_scan;
    logic                 ram_we, ram_re;
    logic [TILE_SIZE-1:0] ram_rdata, masked;
    logic                 any;
    logic [CRD_W-1:0]     hb, lb;
    t_res                 imm_res, scan_res;

    assign is_write   = !i_cmd_empty && (i_cmd.kind == KIND_WRITE);
    assign is_query   = !i_cmd_empty && (i_cmd.kind == KIND_QUERY) && !i_res_full;
    assign row_ok     = ((CRD_W + 1)'(i_cmd.row_idx) < (CRD_W + 1)'(TILE_SIZE));
    assign o_cmd_pop  = (r_state == S_IDLE) && (is_write || is_query);
    assign ram_we     = (r_state == S_IDLE) && is_write && row_ok;
    assign start_scan = (r_state == S_IDLE) && is_query && !i_cmd.empty
                     && (i_mode == MODE_MASK);
    assign ram_re     = (r_state == S_SCAN);

    bdhs_ram #(
        .WIDTH (TILE_SIZE),
        .DEPTH (TILE_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_cmd.row_idx[AW-1:0]),
        .i_wdata (i_cmd.row_bits[TILE_SIZE-1:0]),
        .i_re    (ram_re),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        for (int i = 0; i < TILE_SIZE; i++) begin
            n_cm[i] = ((CRD_W + 1)'(i) >= (CRD_W + 1)'(i_cmd.x0))
                   && ((CRD_W + 1)'(i) <= (CRD_W + 1)'(i_cmd.x1));
        end
    end

    // rows never written read as zero
    assign masked = r_rd_vld ? (ram_rdata & r_cm) : '0;
    assign any    = |masked;

    always_comb begin
        hb = '0;
        lb = '0;
        for (int i = 0; i < TILE_SIZE; i++) begin
            if (masked[i]) begin
                hb = CRD_W'(i);
            end
        end
        for (int i = TILE_SIZE - 1; i >= 0; i--) begin
            if (masked[i]) begin
                lb = CRD_W'(i);
            end
        end
    end

    // solid tile and no-obstacle answers need no scan
    always_comb begin
        imm_res = '0;
        if (!i_cmd.empty && (i_mode == MODE_SOLID)) begin
            imm_res.hit = 1'b1;
            if ((i_cmd.dir == DIR_LEFT) || (i_cmd.dir == DIR_RIGHT)) begin
                imm_res.hit_x = i_cmd.ox + OFS_W'((i_cmd.dir == DIR_LEFT) ? i_cmd.x1
                                                                          : i_cmd.x0);
            end
            imm_res.hit_y = i_cmd.oy + OFS_W'((i_cmd.dir == DIR_BOTTOM) ? i_cmd.y0
                                                                        : i_cmd.y1);
        end
    end

    always_comb begin
        scan_res = '0;
        if (r_found) begin
            scan_res.hit = 1'b1;
            if ((r_dir == DIR_LEFT) || (r_dir == DIR_RIGHT)) begin
                scan_res.hit_x = r_ox + OFS_W'(r_hx);
            end
            scan_res.hit_y = r_oy + OFS_W'(r_hy);
        end
    end

    assign o_res_push = ((r_state == S_IDLE) && is_query && !start_scan) || (r_state == S_OUT);
    assign o_res      = (r_state == S_OUT) ? scan_res : imm_res;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start_scan) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_addr == r_y0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN:   n_state = S_OUT;
            S_OUT:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row_vld <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rd_pend <= (r_state == S_SCAN);
            if (ram_we) begin
                r_row_vld[i_cmd.row_idx[AW-1:0]] <= 1'b1;
            end
        end
    end

    // scan runs from the bottom row up, so strict compares keep the bottommost tie
    always_ff @(posedge i_clk) begin
        if (start_scan) begin
            r_dir   <= i_cmd.dir;
            r_y0    <= i_cmd.y0;
            r_addr  <= i_cmd.y1;
            r_cm    <= n_cm;
            r_ox    <= i_cmd.ox;
            r_oy    <= i_cmd.oy;
            r_found <= 1'b0;
            r_hx    <= '0;
            r_hy    <= '0;
        end else begin
            if (r_state == S_SCAN) begin
                r_addr <= r_addr - 1'b1;
            end
            if (r_rd_pend && any) begin
                r_found <= 1'b1;
                unique case (r_dir)
                    DIR_LEFT: begin
                        if (!r_found || (hb > r_hx)) begin
                            r_hx <= hb;
                            r_hy <= r_rd_row;
                        end
                    end
                    DIR_RIGHT: begin
                        if (!r_found || (lb < r_hx)) begin
                            r_hx <= lb;
                            r_hy <= r_rd_row;
                        end
                    end
                    DIR_TOP: begin
                        if (!r_found) begin
                            r_hy <= r_rd_row;
                        end
                    end
                    DIR_BOTTOM: r_hy <= r_rd_row;
                    default: r_hy <= r_hy;
                endcase
            end
        end
        r_rd_row <= r_addr;
        r_rd_vld <= r_row_vld[r_addr[AW-1:0]];
    end

    `ASSERT_NEVER(a_res_overflow, i_clk, i_rst_n, o_res_push && i_res_full, "result pushed into full queue")
    `ASSERT_NEVER(a_scan_range, i_clk, i_rst_n, (r_state == S_SCAN) && (r_addr < r_y0), "scan passed top row")
    `ASSERT_CLK(a_rd_follow, i_clk, i_rst_n, r_rd_pend |-> ($past(r_state) == S_SCAN), "read data without read")
    `ASSERT_NEVER(a_pop_busy, i_clk, i_rst_n, o_cmd_pop && (r_state != S_IDLE), "command taken while scanning")

endmodule
